FILE: hdl/rtra_pkg.sv
// Shared types, constants and the control-store ROM of the real-to-rational approximator.
// No dependencies; every other file imports this package.
`default_nettype none

package rtra_pkg;

   localparam int unsigned DATA_W        = 64;
   localparam int unsigned DEN_W         = 31;
   localparam int unsigned K_W           = DEN_W + 1;
   localparam int unsigned RSP_W         = ((DATA_W + DEN_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD       = RSP_W - DATA_W - DEN_W;
   localparam int unsigned FRAC_BITS_DEF = 32;
   localparam int unsigned PC_W          = 4;

   localparam logic [DATA_W-1:0] NUM_LIMIT  = 64'h4000_0000_0000_0000;
   localparam logic [DATA_W-1:0] QUOT_LIMIT = 64'h0000_0000_7FFF_FFFF;
   localparam logic [DEN_W-1:0]  DEN_RESET  = 31'd1000000;

   // micro-operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_IDLE,
      OP_DIV_THR,
      OP_SPLIT,
      OP_DIV_QR,
      OP_DWAIT,
      OP_MSTART,
      OP_MWAIT,
      OP_UPD,
      OP_SHIFT,
      OP_ZERO,
      OP_OUT
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      CD_NEXT,
      CD_ALWAYS,
      CD_BELOW,
      CD_MOVF,
      CD_RZERO,
      CD_NCBIG
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic busy;
      logic ovf;
   } mac_stat_type;

   // step addresses
   localparam logic [PC_W-1:0] ST_ACCEPT    = 4'd0;
   localparam logic [PC_W-1:0] ST_THR_GO    = 4'd1;
   localparam logic [PC_W-1:0] ST_THR_WAIT  = 4'd2;
   localparam logic [PC_W-1:0] ST_THR_TEST  = 4'd3;
   localparam logic [PC_W-1:0] ST_SPLIT     = 4'd4;
   localparam logic [PC_W-1:0] ST_SPLIT_NOP = 4'd5;
   localparam logic [PC_W-1:0] ST_LOOP      = 4'd6;
   localparam logic [PC_W-1:0] ST_MAC_WAIT  = 4'd7;
   localparam logic [PC_W-1:0] ST_UPDATE    = 4'd8;
   localparam logic [PC_W-1:0] ST_REM_TEST  = 4'd9;
   localparam logic [PC_W-1:0] ST_QR_GO     = 4'd10;
   localparam logic [PC_W-1:0] ST_QR_WAIT   = 4'd11;
   localparam logic [PC_W-1:0] ST_SHIFT     = 4'd12;
   localparam logic [PC_W-1:0] ST_OUT       = 4'd13;
   localparam logic [PC_W-1:0] ST_ZERO      = 4'd14;

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] addr);
      uword_type w;
      case (addr)
         ST_ACCEPT:    w = '{OP_IDLE,    CD_NEXT,   ST_ACCEPT};
         ST_THR_GO:    w = '{OP_DIV_THR, CD_NEXT,   ST_ACCEPT};
         ST_THR_WAIT:  w = '{OP_DWAIT,   CD_NEXT,   ST_ACCEPT};
         ST_THR_TEST:  w = '{OP_NOP,     CD_BELOW,  ST_ZERO};
         ST_SPLIT:     w = '{OP_SPLIT,   CD_NEXT,   ST_ACCEPT};
         ST_SPLIT_NOP: w = '{OP_NOP,     CD_NEXT,   ST_ACCEPT};
         ST_LOOP:      w = '{OP_MSTART,  CD_NEXT,   ST_ACCEPT};
         ST_MAC_WAIT:  w = '{OP_MWAIT,   CD_NEXT,   ST_ACCEPT};
         ST_UPDATE:    w = '{OP_UPD,     CD_MOVF,   ST_OUT};
         ST_REM_TEST:  w = '{OP_NOP,     CD_RZERO,  ST_OUT};
         ST_QR_GO:     w = '{OP_DIV_QR,  CD_NEXT,   ST_ACCEPT};
         ST_QR_WAIT:   w = '{OP_DWAIT,   CD_NEXT,   ST_ACCEPT};
         ST_SHIFT:     w = '{OP_SHIFT,   CD_NCBIG,  ST_LOOP};
         ST_OUT:       w = '{OP_OUT,     CD_ALWAYS, ST_ACCEPT};
         ST_ZERO:      w = '{OP_ZERO,    CD_ALWAYS, ST_OUT};
         default:      w = '{OP_NOP,     CD_ALWAYS, ST_ACCEPT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/rtra_div.sv
// Iterative unsigned 64-bit divider: align-up then restore-down, one bit per cycle.
// Depends on rtra_pkg.
`default_nettype none

module rtra_div import rtra_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output logic                   busy,
   output logic [DATA_W-1:0]      quotient,
   output logic [DATA_W-1:0]      remainder
);

   typedef enum logic [2:0] {
      DV_IDLE  = 3'b001,
      DV_ALIGN = 3'b010,
      DV_SUB   = 3'b100
   } div_phase_type;

   div_phase_type     phase_ff, phase_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [DATA_W-1:0] bit_ff, bit_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W:0]   den_dbl;
   logic              dbl_fits;
   logic              sub_ok;

   assign den_dbl  = {den_ff, 1'b0};
   assign dbl_fits = den_dbl <= {1'b0, rem_ff};
   assign sub_ok   = rem_ff >= den_ff;

   always_comb begin
      phase_in = phase_ff;
      den_in   = den_ff;
      bit_in   = bit_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start) begin
         phase_in = DV_ALIGN;
         den_in   = divisor;
         bit_in   = {{(DATA_W-1){1'b0}}, 1'b1};
         quo_in   = '0;
         rem_in   = dividend;
      end else begin
         case (phase_ff)
            DV_ALIGN: begin
               if (dbl_fits) begin
                  den_in = den_dbl[DATA_W-1:0];
                  bit_in = {bit_ff[DATA_W-2:0], 1'b0};
               end else begin
                  phase_in = DV_SUB;
               end
            end
            DV_SUB: begin
               if (sub_ok) begin
                  rem_in = rem_ff - den_ff;
                  quo_in = quo_ff | bit_ff;
               end
               den_in = den_ff >> 1;
               bit_in = bit_ff >> 1;
               if (bit_ff == {{(DATA_W-1){1'b0}}, 1'b1}) begin
                  phase_in = DV_IDLE;
               end
            end
            default: phase_in = DV_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= DV_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      bit_ff <= bit_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy      = phase_ff != DV_IDLE;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: hdl/rtra_mac.sv
// Dual bit-serial multiply-add (h*a+h0, k*a+k0) with early bound check.
// Depends on rtra_pkg.
`default_nettype none

module rtra_mac import rtra_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] mult,
   input  wire logic [DATA_W-1:0] h_mul,
   input  wire logic [DATA_W-1:0] h_add,
   input  wire logic [K_W-1:0]    k_mul,
   input  wire logic [K_W-1:0]    k_add,
   input  wire logic [K_W-1:0]    k_bound,
   output logic [DATA_W-1:0]      h_acc,
   output logic [K_W-1:0]         k_acc,
   output mac_stat_type           stat
);

   logic [DATA_W-1:0] mult_ff, mult_in;
   logic [DATA_W-1:0] hm_ff, hm_in;
   logic [DATA_W-1:0] ha_ff, ha_in;
   logic [K_W-1:0]    km_ff, km_in;
   logic [K_W-1:0]    ka_ff, ka_in;
   logic [K_W-1:0]    kb_ff, kb_in;
   logic              busy_ff, busy_in;
   logic              ovf_ff, ovf_in;

   logic [DATA_W-1:0] h_new, hm_nxt, mult_nxt;
   logic [K_W-1:0]    k_new, km_nxt;
   logic              ovf_now;

   // operands stay within the bound while running, so the sums never wrap
   assign h_new    = mult_ff[0] ? ha_ff + hm_ff : ha_ff;
   assign k_new    = mult_ff[0] ? ka_ff + km_ff : ka_ff;
   assign hm_nxt   = hm_ff << 1;
   assign km_nxt   = km_ff << 1;
   assign mult_nxt = mult_ff >> 1;
   assign ovf_now  = (h_new > NUM_LIMIT) || (k_new > kb_ff) ||
                     ((mult_nxt != '0) && ((hm_nxt > NUM_LIMIT) || (km_nxt > kb_ff)));

   always_comb begin
      mult_in = mult_ff;
      hm_in   = hm_ff;
      ha_in   = ha_ff;
      km_in   = km_ff;
      ka_in   = ka_ff;
      kb_in   = kb_ff;
      busy_in = busy_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         mult_in = mult;
         hm_in   = h_mul;
         ha_in   = h_add;
         km_in   = k_mul;
         ka_in   = k_add;
         kb_in   = k_bound;
         busy_in = mult != '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         mult_in = mult_nxt;
         hm_in   = hm_nxt;
         ha_in   = h_new;
         km_in   = km_nxt;
         ka_in   = k_new;
         ovf_in  = ovf_now;
         busy_in = !ovf_now && (mult_nxt != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ovf_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      mult_ff <= mult_in;
      hm_ff   <= hm_in;
      ha_ff   <= ha_in;
      km_ff   <= km_in;
      ka_ff   <= ka_in;
      kb_ff   <= kb_in;
   end

   assign h_acc     = ha_ff;
   assign k_acc     = ka_ff;
   assign stat.busy = busy_ff;
   assign stat.ovf  = ovf_ff;

endmodule

`default_nettype wire

FILE: hdl/real_to_rational_approximator.sv
// Timing: set by the shared bit-serial divider and multiply-add and by the number of expansion
//   steps; an item below thr skips the expansion.
// Throughput: one item at a time; the next item is taken while a result still waits.
// Reset: synchronous, clears the sequencer, handshake flags and unit status, and sets
//   max_denominator to 1000000. No clearing pass.
`default_nettype none

module real_to_rational_approximator import rtra_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,   // [63:0] real_value
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,   // [63:0] numerator, [94:64] denominator
   input  wire logic              csr_wen,
   input  wire logic [DEN_W-1:0]  csr_wdata    // max_denominator
);

   // fixed-point one, the first divisor of the expansion
   localparam logic [DATA_W-1:0] ONE       = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic [DATA_W-1:0] FRAC_MASK = ONE - {{(DATA_W-1){1'b0}}, 1'b1};

   // ---------------------------------------------------------------- registers
   logic [DEN_W-1:0]  cfg_lim_ff;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] mag_ff, mag_in;
   logic [DEN_W-1:0]  lim_ff, lim_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic [DATA_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] a_ff, a_in;                    // current partial quotient
   logic [DATA_W-1:0] h0_ff, h0_in, h1_ff, h1_in;   // convergent numerators
   logic [DEN_W-1:0]  k0_ff, k0_in, k1_ff, k1_in;   // convergent denominators
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_num_ff, rsp_num_in;
   logic [DEN_W-1:0]  rsp_den_ff, rsp_den_in;

   // ---------------------------------------------------------------- control
   uword_type         uw;
   logic              accept;
   logic              hold;
   logic              take;
   logic              out_load;
   logic              c_big;

   // ---------------------------------------------------------------- units
   logic              div_start, div_busy;
   logic [DATA_W-1:0] div_dvd, div_dvs, div_quo, div_rem;
   logic              mac_start;
   logic [DATA_W-1:0] mac_h_acc;
   logic [K_W-1:0]    mac_k_acc;
   mac_stat_type      mac_stat;

   assign uw         = ucode_rom(pc_ff);
   assign req_tready = uw.op == OP_IDLE;
   assign accept     = req_tvalid && req_tready;

   // next complete quotient too large: stop the expansion
   assign c_big = (div_quo > QUOT_LIMIT) || ((div_quo == QUOT_LIMIT) && (div_rem != '0));

   always_comb begin
      case (uw.op)
         OP_IDLE:  hold = !accept;
         OP_DWAIT: hold = div_busy;
         OP_MWAIT: hold = mac_stat.busy;
         OP_OUT:   hold = rsp_valid_ff && !rsp_tready;
         default:  hold = 1'b0;
      endcase
   end

   always_comb begin
      case (uw.cond)
         CD_NEXT:   take = 1'b0;
         CD_ALWAYS: take = 1'b1;
         CD_BELOW:  take = mag_ff < div_quo;     // below ceil(one/lim): result 0/1
         CD_MOVF:   take = mac_stat.ovf;         // next convergent out of bounds
         CD_RZERO:  take = r_ff == '0;           // exact expansion
         CD_NCBIG:  take = !c_big;               // keep going
         default:   take = 1'b0;
      endcase
   end

   assign pc_in = hold ? pc_ff :
                  take ? uw.target : pc_ff + {{(PC_W-1){1'b0}}, 1'b1};

   // divider operand select
   assign div_start = uw.op inside {OP_DIV_THR, OP_DIV_QR};

   always_comb begin
      div_dvd = q_ff;
      div_dvs = r_ff;
      case (uw.op)
         OP_DIV_THR: begin
            div_dvd = ONE + {{(DATA_W-DEN_W){1'b0}}, lim_ff} - {{(DATA_W-1){1'b0}}, 1'b1};
            div_dvs = {{(DATA_W-DEN_W){1'b0}}, lim_ff};
         end
         default: begin
            div_dvd = q_ff;
            div_dvs = r_ff;
         end
      endcase
   end

   assign mac_start = uw.op == OP_MSTART;
   assign out_load  = (uw.op == OP_OUT) && !hold;

   // datapath actions of each step
   always_comb begin
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      lim_in     = lim_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      a_in       = a_ff;
      h0_in      = h0_ff;
      h1_in      = h1_ff;
      k0_in      = k0_ff;
      k1_in      = k1_ff;
      rsp_num_in = rsp_num_ff;
      rsp_den_in = rsp_den_ff;
      case (uw.op)
         OP_IDLE: begin
            if (accept) begin
               neg_in = req_tdata[DATA_W-1];
               mag_in = req_tdata[DATA_W-1] ? {DATA_W{1'b0}} - req_tdata : req_tdata;
               lim_in = (cfg_lim_ff == '0) ? {{(DEN_W-1){1'b0}}, 1'b1} : cfg_lim_ff;
               q_in   = ONE;
               h1_in  = {{(DATA_W-1){1'b0}}, 1'b1};
               h0_in  = '0;
               k1_in  = '0;
               k0_in  = {{(DEN_W-1){1'b0}}, 1'b1};
            end
         end
         // first step divides by one: integer part and fraction bits
         OP_SPLIT: begin
            a_in = mag_ff >> FRAC_BITS;
            r_in = mag_ff & FRAC_MASK;
         end
         OP_UPD: begin
            if (!mac_stat.ovf) begin
               h0_in = h1_ff;
               h1_in = mac_h_acc;
               k0_in = k1_ff;
               k1_in = mac_k_acc[DEN_W-1:0];
            end
         end
         OP_SHIFT: begin
            q_in = r_ff;
            r_in = div_rem;
            a_in = div_quo;
         end
         OP_ZERO: begin
            h1_in = '0;
            k1_in = {{(DEN_W-1){1'b0}}, 1'b1};
         end
         OP_OUT: begin
            if (out_load) begin
               rsp_num_in = neg_ff ? {DATA_W{1'b0}} - h1_ff : h1_ff;
               rsp_den_in = k1_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // output register: holds a result while the sequencer takes the next item
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_lim_ff   <= DEN_RESET;
         pc_ff        <= ST_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            cfg_lim_ff <= csr_wdata;
         end
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      lim_ff     <= lim_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      a_ff       <= a_in;
      h0_ff      <= h0_in;
      h1_ff      <= h1_in;
      k0_ff      <= k0_in;
      k1_ff      <= k1_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   // ---------------------------------------------------------------- units
   rtra_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // h*a+h0 against 2^62, k*a+k0 against the limit
   rtra_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .mult    (a_ff),
      .h_mul   (h1_ff),
      .h_add   (h0_ff),
      .k_mul   ({1'b0, k1_ff}),
      .k_add   ({1'b0, k0_ff}),
      .k_bound ({1'b0, lim_ff}),
      .h_acc   (mac_h_acc),
      .k_acc   (mac_k_acc),
      .stat    (mac_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_den_ff, rsp_num_ff};

   // ---------------------------------------------------------------- checks
   // every division is waited for before the next one starts
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // a finished multiply-add without overflow stays within the numerator bound
   a_mac_bound: assert property (@(posedge clock) disable iff (reset)
      ($fell(mac_stat.busy) && !mac_stat.ovf) |-> (mac_h_acc <= NUM_LIMIT))
      else $error("numerator bound missed");

   // a delivered denominator is never zero
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_den_ff != '0))
      else $error("zero denominator");

endmodule

`default_nettype wire

FILE: test/rational_result_checker.sv
// Scoreboard for the real-to-rational approximator: watches the request, result and CSR ports,
// predicts each fraction from the continued-fraction expansion and compares. Uses rtra_pkg.
module rational_result_checker
   import rtra_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [RSP_W-1:0] rsp_tdata,
   input  wire logic             csr_wen,
   input  wire logic [DEN_W-1:0] csr_wdata,
   output int                    failures,
   output int                    pending
);

   localparam int unsigned FRAC_BITS = FRAC_BITS_DEF;

   typedef struct packed {
      logic [DATA_W-1:0] numerator;
      logic [DEN_W-1:0]  denominator;
   } fraction_type;

   fraction_type     expected_fractions[$];
   logic [DEN_W-1:0] limit_copy = DEN_RESET;
   int               mismatch_count = 0;
   int               queued_count = 0;

   assign failures = mismatch_count;
   assign pending  = queued_count;

   // last convergent with denominator <= limit, by Euclid steps on mag / 2^FRAC_BITS
   function automatic fraction_type approximate_rational(input logic [DATA_W-1:0] raw,
                                                         input logic [DEN_W-1:0] limit_reg);
      fraction_type f;
      logic        neg;
      logic [63:0] mag, lim, one, thr, num, den;
      logic [63:0] p, q, h1, h0, k1, k0, ai, r, c, t;
      bit          done;
      neg = raw[DATA_W-1];
      mag = neg ? (64'd0 - raw) : raw;
      lim = (limit_reg == '0) ? 64'd1 : {33'd0, limit_reg};
      one = 64'd1 << FRAC_BITS;
      thr = (one + lim - 64'd1) / lim;
      num = 64'd0;
      den = 64'd1;
      if (mag >= thr) begin
         p = mag;
         q = one;
         h1 = 64'd1;
         h0 = 64'd0;
         k1 = 64'd0;
         k0 = 64'd1;
         done = 1'b0;
         while (!done) begin
            ai = p / q;
            if (k1 != 0 && ai > (lim - k0) / k1) begin
               done = 1'b1;
            end else if (ai != 0 && h1 > (NUM_LIMIT - h0) / ai) begin
               done = 1'b1;
            end else begin
               t  = h1 * ai + h0;
               h0 = h1;
               h1 = t;
               t  = k1 * ai + k0;
               k0 = k1;
               k1 = t;
               r  = p % q;
               if (r == 0) begin
                  done = 1'b1;
               end else begin
                  c = q / r;
                  if (c > QUOT_LIMIT || (c == QUOT_LIMIT && (q % r) != 0)) begin
                     done = 1'b1;
                  end else begin
                     p = q;
                     q = r;
                  end
               end
            end
         end
         num = h1;
         den = k1;
      end
      f.numerator   = neg ? (64'd0 - num) : num;
      f.denominator = den[DEN_W-1:0];
      return f;
   endfunction

   always @(posedge clock) begin
      fraction_type want;
      if (reset) begin
         limit_copy = DEN_RESET;
         expected_fractions.delete();
      end else begin
         if (csr_wen) begin
            limit_copy = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            expected_fractions.push_back(approximate_rational(req_tdata, limit_copy));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_fractions.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_tdata[DATA_W-1:0] !== want.numerator) begin
                  $display("%0t: numerator expected %h actual %h", $time, want.numerator,
                           rsp_tdata[DATA_W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[DATA_W +: DEN_W] !== want.denominator) begin
                  $display("%0t: denominator expected %h actual %h", $time, want.denominator,
                           rsp_tdata[DATA_W +: DEN_W]);
                  mismatch_count++;
               end
            end
         end
      end
      queued_count = expected_fractions.size();
   end

endmodule

FILE: test/tb_real_to_rational_approximator.sv
// Testbench top for real_to_rational_approximator: drives Q31.32 values and max_denominator
// writes, with random idling on both channels. Needs rtra_pkg and rational_result_checker.
module tb_real_to_rational_approximator;
   import rtra_pkg::*;

   localparam int unsigned HOLD_OFF_CYCLES = 12000; // long enough for two worst-case items
   localparam int unsigned DRAIN_CYCLES    = 3000;  // above the worst-case latency of one item
   localparam int unsigned SETTLE_CYCLES   = 16;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic [DATA_W-1:0] req_tdata  = '0;
   logic              rsp_tready = 1'b0;
   logic              csr_wen    = 1'b0;
   logic [DEN_W-1:0]  csr_wdata  = '0;
   wire logic             req_tready;
   wire logic             rsp_tvalid;
   wire logic [RSP_W-1:0] rsp_tdata;

   int failures;
   int pending;

   // idle odds in percent per cycle, changed between phases
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   bit          hold_off_request  = 1'b0;
   logic [DEN_W-1:0] active_limit = DEN_RESET;

   always #5 clock = ~clock;

   real_to_rational_approximator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // [63:0] real_value
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // [63:0] numerator, [94:64] denominator
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)      // max_denominator
   );

   rational_result_checker fraction_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   // smallest magnitude that still expands: ceil(2^32 / limit), limit 0 acts as 1
   function automatic logic [63:0] smallest_magnitude(input logic [DEN_W-1:0] lim);
      logic [63:0] l;
      l = (lim == '0) ? 64'd1 : {33'd0, lim};
      return ((64'd1 << FRAC_BITS_DEF) + l - 64'd1) / l;
   endfunction

   // mostly exact ratios and spread magnitudes; some near the cutoff and at the edges
   function automatic logic [63:0] pick_real_value();
      logic [63:0] v;
      int unsigned a;
      int unsigned b;
      case ($urandom_range(9))
         0, 1, 2: v = {$urandom(), $urandom()} >> $urandom_range(63);
         3, 4, 5: begin
            a = $urandom_range(1, 2000);
            b = $urandom_range(1, 2000);
            v = ({32'd0, a} << FRAC_BITS_DEF) / {32'd0, b};
         end
         6: v = smallest_magnitude(active_limit) + 64'($urandom_range(2)) - 64'd1;
         // integer plus up to three lsbs: next partial quotient can exceed the quotient limit
         7: v = ({32'd0, $urandom()} << FRAC_BITS_DEF) | 64'($urandom_range(3));
         8: v = {$urandom(), $urandom()};
         default: begin
            case ($urandom_range(3))
               0: v = 64'd0;
               1: v = 64'h8000_0000_0000_0000;
               2: v = 64'h7FFF_FFFF_FFFF_FFFF;
               default: v = 64'd1;
            endcase
         end
      endcase
      if ($urandom_range(1)) begin
         v = 64'd0 - v;
      end
      return v;
   endfunction

   // called and returns at a falling edge; tvalid is left high on return
   task automatic offer_value(input logic [DATA_W-1:0] v);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) offer_value(pick_real_value());
   endtask

   // limit writes only with the block drained and idle
   task automatic program_limit(input logic [DEN_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      active_limit = value;
   endtask

   // result side: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   initial begin
      logic [DATA_W-1:0] directed_values[$];
      directed_values = '{
         64'h0000_0000_0000_0000,   // zero
         64'h0000_0000_0000_0001,   // smallest positive, below cutoff
         64'h7FFF_FFFF_FFFF_FFFF,   // largest positive
         64'h8000_0000_0000_0000,   // most negative, magnitude 2^63
         64'hFFFF_FFFF_FFFF_FFFF,   // -1 lsb
         64'h0000_0001_0000_0000,   // 1.0
         64'hFFFF_FFFF_0000_0000,   // -1.0
         64'h0000_0003_243F_6A88,   // pi
         64'hFFFF_FFFC_DBC0_9578,   // -pi
         64'h0000_0002_B7E1_5163,   // e
         64'h0000_0001_6A09_E667,   // sqrt 2
         64'h0000_0001_9E37_79B9,   // golden ratio
         64'h0000_0000_8000_0000,   // 0.5
         64'h0000_0000_5555_5555,   // about 1/3
         64'h0000_0001_0000_0001,   // 1 + lsb: quotient limit stops it
         64'h7FFF_FFFF_0000_0000,   // largest integer
         64'h0000_1234_0000_0000    // plain integer
      };
      // magnitude exactly at the cutoff ceil(2^32 / limit), just below, and negative
      directed_values.push_back(smallest_magnitude(DEN_RESET));
      directed_values.push_back(smallest_magnitude(DEN_RESET) - 64'd1);
      directed_values.push_back(64'd0 - smallest_magnitude(DEN_RESET));

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // phase 1: reset limit, sender idles rarely, receiver mostly
      sender_idle_pct   = 10;
      receiver_idle_pct = 87;
      foreach (directed_values[i]) offer_value(directed_values[i]);
      run_random(40);

      // limit 1: integers only
      program_limit(31'd1);
      offer_value(64'h0000_0000_FFFF_FFFF);
      offer_value(64'h0000_0001_0000_0000);
      run_random(20);

      // widest limit, idle odds swapped
      sender_idle_pct   = 87;
      receiver_idle_pct = 10;
      program_limit(31'h7FFF_FFFF);
      offer_value(smallest_magnitude(31'h7FFF_FFFF));
      offer_value(smallest_magnitude(31'h7FFF_FFFF) - 64'd1);
      run_random(50);

      // zero limit behaves as one
      program_limit(31'd0);
      run_random(10);

      // no idling; receiver holds off long enough to back up the input
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      program_limit(DEN_W'($urandom_range(2, 5000)));
      hold_off_request = 1'b1;
      run_random(40);

      program_limit(DEN_W'($urandom_range(1, 32'h7FFF_FFFF)));
      run_random(35);

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: sim.f
hdl/rtra_pkg.sv
hdl/rtra_div.sv
hdl/rtra_mac.sv
hdl/real_to_rational_approximator.sv
test/rational_result_checker.sv
test/tb_real_to_rational_approximator.sv
